// ===== hw/rtl/baa_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometric altitude package
// Segment table, field widths and limits shared by the altitude datapath.
// ----------------------------------------------------------------------------
package baa_pkg;

    // Field widths fixed by the interface.
    localparam int PRESS_W = 20;
    localparam int ALT_W   = 25;

    // Input clamp limits, in 1/800 hPa.
    localparam logic [PRESS_W-1:0] PRESS_MIN = 20'd200000;
    localparam logic [PRESS_W-1:0] PRESS_MAX = 20'd900000;

    // Number of segments in the approximation.
    localparam int NSEG = 16;

    // One segment: base pressure in 1/800 hPa, base height in mm, slopes.
    typedef struct packed {
        logic        [19:0] base_p;
        logic signed [24:0] base_h;
        logic signed [14:0] c1;
        logic signed [12:0] c2;
    } t_seg;

    // Segment table, ordered from high pressure to low pressure.
    function automatic t_seg seg_lookup(input logic [3:0] idx);
        t_seg s;
        case (idx)
            4'd0:    s = '{20'd824000, -25'sd138507,  -15'sd5252,  13'sd311};
            4'd1:    s = '{20'd784000,  25'sd280531,  -15'sd5468,  13'sd338};
            4'd2:    s = '{20'd744000,  25'sd717253,  -15'sd5704,  13'sd370};
            4'd3:    s = '{20'd704000,  25'sd1173421, -15'sd5964,  13'sd407};
            4'd4:    s = '{20'd664000,  25'sd1651084, -15'sd6252,  13'sd450};
            4'd5:    s = '{20'd624000,  25'sd2152645, -15'sd6573,  13'sd501};
            4'd6:    s = '{20'd584000,  25'sd2680954, -15'sd6934,  13'sd560};
            4'd7:    s = '{20'd544000,  25'sd3239426, -15'sd7342,  13'sd632};
            4'd8:    s = '{20'd504000,  25'sd3832204, -15'sd7808,  13'sd719};
            4'd9:    s = '{20'd464000,  25'sd4464387, -15'sd8345,  13'sd826};
            4'd10:   s = '{20'd424000,  25'sd5142359, -15'sd8972,  13'sd960};
            4'd11:   s = '{20'd384000,  25'sd5874268, -15'sd9714,  13'sd1131};
            4'd12:   s = '{20'd344000,  25'sd6670762, -15'sd10609, 13'sd1354};
            4'd13:   s = '{20'd304000,  25'sd7546157, -15'sd11711, 13'sd1654};
            4'd14:   s = '{20'd264000,  25'sd8520395, -15'sd13103, 13'sd2072};
            default: s = '{20'd224000,  25'sd9622536, -15'sd14926, 13'sd2682};
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/barometric_altitude_approx_top.sv =====
// ----------------------------------------------------------------------------
// Barometric altitude, piecewise quadratic
// Converts a pressure sample to altitude above a programmable ground level
// through a five-stage pipeline: segment select, two slope multiplies, the
// quadratic multiply, the sum and base add, then ground subtract and limit.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Payload
//  ---------+-----------+---------------------------------------------
//  s_axis   | in        | tdata[19:0] pressure_raw (1/800 hPa)
//  m_axis   | out       | tdata[24:0] altitude_mm (signed mm)
//  cfg      | in        | wr_data[24:0] ground_altitude_mm (signed mm)
//
//  One sample is accepted per cycle while no downstream stall holds the pipeline;
//  each result passes through the five register stages.
//  Every stage holds its own valid bit and fills any bubble ahead of it, so
//  a downstream stall loses and repeats nothing.
//  Reset clears the valid bits and the ground altitude register.
//
module barometric_altitude_approx_top
    import baa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration
    input  logic        i_cfg_wr_en,
    input  logic [24:0] i_cfg_wr_data,   // [24:0] ground_altitude_mm
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [19:0] pressure_raw, [23:20] zero
    // Output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata   // [24:0] altitude_mm, [31:25] zero
);

    localparam logic signed [26:0] OUT_HI =  27'sd11600000;
    localparam logic signed [26:0] OUT_LO = -27'sd11600000;

    // Pipeline registers.
    logic               r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic signed [17:0] r1_d, r2_d;
    logic signed [14:0] r1_c1;
    logic signed [12:0] r1_c2;
    logic signed [24:0] r1_bh, r2_bh, r3_bh;
    logic signed [31:0] r2_lin, r3_lin;
    logic signed [13:0] r2_qs;
    logic signed [27:0] r3_quad;
    logic signed [25:0] r4_h;
    logic signed [24:0] r5_alt;
    logic signed [24:0] r_ground;

    // Stage enables: a stage loads when empty or when its successor moves.
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !r5_valid || i_m_axis_tready;
    assign rdy4 = !r4_valid || rdy5;
    assign rdy3 = !r3_valid || rdy4;
    assign rdy2 = !r2_valid || rdy3;
    assign rdy1 = !r1_valid || rdy2;

    assign o_s_axis_tready = rdy1;
    assign o_m_axis_tvalid = r5_valid;
    assign o_m_axis_tdata  = {7'd0, r5_alt};

    // Ground reference register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ground <= '0;
        end else if (i_cfg_wr_en) begin
            r_ground <= i_cfg_wr_data;
        end
    end

    // Stage 1: clamp, segment search and offset from the segment base.
    logic [PRESS_W-1:0] w_raw, w_p;
    logic [3:0]         w_k;
    t_seg               w_seg;
    logic signed [20:0] w_diff;

    assign w_raw = i_s_axis_tdata[PRESS_W-1:0];

    always_comb begin
        if (w_raw < PRESS_MIN) begin
            w_p = PRESS_MIN;
        end else if (w_raw > PRESS_MAX) begin
            w_p = PRESS_MAX;
        end else begin
            w_p = w_raw;
        end
    end

    // The first segment whose base lies at or below the sample wins.
    always_comb begin
        w_k = 4'(NSEG - 1);
        for (int i = NSEG - 2; i >= 0; i--) begin
            if (w_p >= seg_lookup(4'(i)).base_p) begin
                w_k = 4'(i);
            end
        end
    end

    assign w_seg  = seg_lookup(w_k);
    assign w_diff = $signed({1'b0, w_p}) - $signed({1'b0, w_seg.base_p});

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_d  <= w_diff[17:0];
            r1_c1 <= w_seg.c1;
            r1_c2 <= w_seg.c2;
            r1_bh <= w_seg.base_h;
        end
    end

    // Stage 2: linear term and first factor of the quadratic term.
    logic signed [32:0] w_lin_prod;
    logic signed [32:0] w_lin_sh;
    logic signed [31:0] w_q_prod;
    logic signed [31:0] w_q_sh;

    assign w_lin_prod = r1_c1 * r1_d;
    assign w_lin_sh   = w_lin_prod >>> 1;
    assign w_q_prod   = r1_c2 * r1_d;
    assign w_q_sh     = w_q_prod >>> 14;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_lin <= w_lin_sh[31:0];
            r2_qs  <= w_q_sh[13:0];
            r2_d   <= r1_d;
            r2_bh  <= r1_bh;
        end
    end

    // Stage 3: second factor of the quadratic term.
    logic signed [31:0] w_quad_prod;
    logic signed [31:0] w_quad_sh;

    assign w_quad_prod = r2_qs * r2_d;
    assign w_quad_sh   = w_quad_prod >>> 4;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_lin  <= r2_lin;
            r3_quad <= w_quad_sh[27:0];
            r3_bh   <= r2_bh;
        end
    end

    // Stage 4: sum the terms, scale and add the segment base height.
    logic signed [32:0] w_sum;
    logic signed [32:0] w_sum_sh;
    logic signed [25:0] w_h;

    assign w_sum    = r3_lin + r3_quad;
    assign w_sum_sh = w_sum >>> 8;
    assign w_h      = $signed(w_sum_sh[25:0]) + r3_bh;

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_h <= w_h;
        end
    end

    // Stage 5: subtract the ground reference and limit the result.
    logic signed [26:0] w_r;
    logic signed [26:0] w_r_lim;

    assign w_r = r4_h - r_ground;

    always_comb begin
        if (w_r > OUT_HI) begin
            w_r_lim = OUT_HI;
        end else if (w_r < OUT_LO) begin
            w_r_lim = OUT_LO;
        end else begin
            w_r_lim = w_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r5_alt <= w_r_lim[24:0];
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            if (rdy1) r1_valid <= i_s_axis_tvalid;
            if (rdy2) r2_valid <= r1_valid;
            if (rdy3) r3_valid <= r2_valid;
            if (rdy4) r4_valid <= r3_valid;
            if (rdy5) r5_valid <= r4_valid;
        end
    end

    // A presented result always lies inside the output limits.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_valid |-> (r5_alt <= 25'sd11600000 && r5_alt >= -25'sd11600000))
        else $error("altitude result outside output limits");

    // An accepted sample always occupies the first stage next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r1_valid)
        else $error("accepted sample lost at stage one");

    // Input back-pressure only appears when every stage is full.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r1_valid && r2_valid && r3_valid && r4_valid && r5_valid))
        else $error("input stalled while the pipeline has a bubble");

    // A stage-four result moves into the output register when it has room.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_valid && rdy5) |=> r5_valid)
        else $error("result lost between stage four and the output");

endmodule
